// ===== rtl/fjot_pkg.sv =====
// ----------------------------------------------------------------------------
// fjot_pkg: shared types and constants for the flat JSON object tokenizer
// Transaction payloads, result kinds, status and error codes, character set.
// ----------------------------------------------------------------------------
package fjot_pkg;

    // Input transaction: one character of object text
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_item_t;

    // Output transaction: one result per character
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_char;
        logic [7:0]  string_length;
        logic [1:0]  status;
        logic [3:0]  error_code;
        logic [10:0] error_position;
    } out_item_t;

    // Result kinds
    localparam logic [2:0] KIND_NONE      = 3'd0;
    localparam logic [2:0] KIND_KEY_CHAR  = 3'd1;
    localparam logic [2:0] KIND_VAL_CHAR  = 3'd2;
    localparam logic [2:0] KIND_KEY_CLOSE = 3'd3;
    localparam logic [2:0] KIND_VAL_CLOSE = 3'd4;

    // Status codes
    localparam logic [1:0] STATUS_BUSY     = 2'd0;
    localparam logic [1:0] STATUS_COMPLETE = 2'd1;
    localparam logic [1:0] STATUS_ERROR    = 2'd2;

    // Error codes
    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_BRACE        = 4'd1;
    localparam logic [3:0] ERR_QUOTE_AFTER  = 4'd2;
    localparam logic [3:0] ERR_QUOTE_BEFORE = 4'd3;
    localparam logic [3:0] ERR_COLON        = 4'd4;
    localparam logic [3:0] ERR_CLOSE_BRACE  = 4'd5;
    localparam logic [3:0] ERR_STRAY        = 4'd6;
    localparam logic [3:0] ERR_INCOMPLETE   = 4'd7;
    localparam logic [3:0] ERR_TOO_LONG     = 4'd8;

    // Syntax characters
    localparam logic [7:0] CH_OPEN_BRACE  = 8'h7B;
    localparam logic [7:0] CH_QUOTE       = 8'h22;
    localparam logic [7:0] CH_COLON       = 8'h3A;
    localparam logic [7:0] CH_COMMA       = 8'h2C;
    localparam logic [7:0] CH_CLOSE_BRACE = 8'h7D;
    localparam logic [7:0] CH_SPACE       = 8'h20;

    // Width of the character position index
    localparam int POS_WIDTH = 11;

endpackage

// ===== rtl/fjot_in_stage.sv =====
// ----------------------------------------------------------------------------
// fjot_in_stage: input register of the tokenizer
// Captures one character transaction and holds it until the core takes it.
// ----------------------------------------------------------------------------
module fjot_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fjot_pkg::in_item_t in_data,
    input  logic               take,
    output logic               item_valid,
    output fjot_pkg::in_item_t item
);

    logic               vld_reg;
    logic               vld_next;
    fjot_pkg::in_item_t data_reg;
    logic               load;

    // Accept when empty or when the held item leaves this cycle
    assign in_ready = !vld_reg || take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
    end

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= in_data;
        end
    end

    assign item_valid = vld_reg;
    assign item       = data_reg;

endmodule

// ===== rtl/fjot_core.sv =====
// ----------------------------------------------------------------------------
// fjot_core: phase machine of the tokenizer
// Decodes one character per step, updates the phase, string count, position
// and held error, and forms the result transaction.
// ----------------------------------------------------------------------------
module fjot_core #(
    parameter int MAX_STRING = 255,
    parameter int MAX_INPUT  = 2048
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  fjot_pkg::in_item_t  item,
    output fjot_pkg::out_item_t result
);

    localparam int PosCapInt = ((MAX_INPUT - 1) < 2047) ? (MAX_INPUT - 1) : 2047;
    localparam logic [fjot_pkg::POS_WIDTH-1:0] PosCap = fjot_pkg::POS_WIDTH'(PosCapInt);
    localparam logic [7:0] MaxStr = 8'(MAX_STRING);

    // Phase codes
    localparam logic [2:0] PH_NONE     = 3'd0;
    localparam logic [2:0] PH_OBJ      = 3'd1;
    localparam logic [2:0] PH_KEY      = 3'd2;
    localparam logic [2:0] PH_KEY_DONE = 3'd3;
    localparam logic [2:0] PH_VAL      = 3'd4;
    localparam logic [2:0] PH_VAL_DONE = 3'd5;
    localparam logic [2:0] PH_CLOSED   = 3'd6;
    localparam logic [2:0] PH_ERROR    = 3'd7;

    logic [2:0]                      phase_reg, phase_next;
    logic [7:0]                      count_reg, count_next;
    logic [fjot_pkg::POS_WIDTH-1:0]  pos_reg, pos_next;
    logic [3:0]                      err_reg, err_next;
    logic [fjot_pkg::POS_WIDTH-1:0]  err_pos_reg, err_pos_next;
    logic [7:0]                      c;

    assign c = item.ch;

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        err_next     = err_reg;
        err_pos_next = err_pos_reg;
        pos_next     = pos_reg;
        result       = '0;

        // Decode the character against the current phase
        unique case (phase_reg)
            PH_ERROR:
            begin
            end
            PH_KEY, PH_VAL:
            begin
                if (c == fjot_pkg::CH_QUOTE)
                begin
                    result.kind = (phase_reg == PH_KEY) ? fjot_pkg::KIND_KEY_CLOSE
                                                        : fjot_pkg::KIND_VAL_CLOSE;
                    result.string_length = count_reg;
                    phase_next = (phase_reg == PH_KEY) ? PH_KEY_DONE : PH_VAL_DONE;
                    count_next = '0;
                end
                else if (count_reg >= MaxStr)
                begin
                    phase_next   = PH_ERROR;
                    err_next     = fjot_pkg::ERR_TOO_LONG;
                    err_pos_next = pos_reg;
                end
                else
                begin
                    result.kind = (phase_reg == PH_KEY) ? fjot_pkg::KIND_KEY_CHAR
                                                        : fjot_pkg::KIND_VAL_CHAR;
                    result.out_char = c;
                    count_next = count_reg + 8'd1;
                end
            end
            PH_CLOSED:
            begin
                if (c != fjot_pkg::CH_SPACE)
                begin
                    phase_next   = PH_ERROR;
                    err_next     = fjot_pkg::ERR_STRAY;
                    err_pos_next = pos_reg;
                end
            end
            PH_NONE, PH_OBJ, PH_KEY_DONE, PH_VAL_DONE:
            begin
                if (c == fjot_pkg::CH_OPEN_BRACE)
                begin
                    if (phase_reg == PH_NONE)
                    begin
                        phase_next = PH_OBJ;
                    end
                    else
                    begin
                        phase_next   = PH_ERROR;
                        err_next     = fjot_pkg::ERR_BRACE;
                        err_pos_next = pos_reg;
                    end
                end
                else if (c == fjot_pkg::CH_QUOTE)
                begin
                    if (phase_reg == PH_OBJ)
                    begin
                        phase_next = PH_KEY;
                        count_next = '0;
                    end
                    else if (phase_reg == PH_KEY_DONE)
                    begin
                        phase_next = PH_VAL;
                        count_next = '0;
                    end
                    else
                    begin
                        phase_next   = PH_ERROR;
                        err_next     = (phase_reg == PH_VAL_DONE) ? fjot_pkg::ERR_QUOTE_AFTER
                                                                  : fjot_pkg::ERR_QUOTE_BEFORE;
                        err_pos_next = pos_reg;
                    end
                end
                else if (c == fjot_pkg::CH_COLON)
                begin
                    if (phase_reg == PH_OBJ || phase_reg == PH_VAL_DONE)
                    begin
                        phase_next   = PH_ERROR;
                        err_next     = fjot_pkg::ERR_COLON;
                        err_pos_next = pos_reg;
                    end
                end
                else if (c == fjot_pkg::CH_COMMA)
                begin
                    if (phase_reg == PH_VAL_DONE)
                    begin
                        phase_next = PH_OBJ;
                    end
                end
                else if (c == fjot_pkg::CH_CLOSE_BRACE)
                begin
                    if (phase_reg == PH_VAL_DONE)
                    begin
                        phase_next = PH_CLOSED;
                    end
                    else
                    begin
                        phase_next   = PH_ERROR;
                        err_next     = fjot_pkg::ERR_CLOSE_BRACE;
                        err_pos_next = pos_reg;
                    end
                end
                else if (c != fjot_pkg::CH_SPACE)
                begin
                    phase_next   = PH_ERROR;
                    err_next     = fjot_pkg::ERR_STRAY;
                    err_pos_next = pos_reg;
                end
            end
            default:
            begin
            end
        endcase

        // Flag an unfinished object on the last character
        if (item.last && phase_next != PH_CLOSED && phase_next != PH_ERROR)
        begin
            phase_next   = PH_ERROR;
            err_next     = fjot_pkg::ERR_INCOMPLETE;
            err_pos_next = pos_reg;
        end

        // Error replaces any character or marker
        if (phase_next == PH_ERROR)
        begin
            result.kind           = fjot_pkg::KIND_NONE;
            result.out_char       = '0;
            result.string_length  = '0;
            result.status         = fjot_pkg::STATUS_ERROR;
            result.error_code     = err_next;
            result.error_position = err_pos_next;
        end
        else if (item.last)
        begin
            result.status = fjot_pkg::STATUS_COMPLETE;
        end

        // Rearm after the last character, else advance the position
        if (item.last)
        begin
            phase_next   = PH_NONE;
            count_next   = '0;
            pos_next     = '0;
            err_next     = fjot_pkg::ERR_NONE;
            err_pos_next = '0;
        end
        else if (pos_reg < PosCap)
        begin
            pos_next = pos_reg + {{(fjot_pkg::POS_WIDTH-1){1'b0}}, 1'b1};
        end
    end

    // Advance state on each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_NONE;
            count_reg   <= '0;
            pos_reg     <= '0;
            err_reg     <= fjot_pkg::ERR_NONE;
            err_pos_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            err_reg     <= err_next;
            err_pos_reg <= err_pos_next;
        end
    end

endmodule

// ===== rtl/fjot_out_stage.sv =====
// ----------------------------------------------------------------------------
// fjot_out_stage: result register of the tokenizer
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module fjot_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_valid,
    output logic                load_ready,
    input  fjot_pkg::out_item_t load_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fjot_pkg::out_item_t out_data
);

    logic                vld_reg;
    logic                vld_next;
    fjot_pkg::out_item_t data_reg;
    logic                load;

    // Free when empty or when the held result is taken this cycle
    assign load_ready = !vld_reg || out_ready;
    assign load       = load_valid && load_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            vld_next = 1'b0;
        end
    end

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/flat_json_object_tokenizer.sv =====
// ----------------------------------------------------------------------------
// flat_json_object_tokenizer: streaming tokenizer for flat JSON objects
// Splits quoted keys and values into tagged characters and close markers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one character per
//   transaction; in_data.last marks the final character of an object, after
//   which the block rearms for the next object.
//   Output channel (out_valid/out_ready/out_data) gives exactly one result
//   transaction per character, in order.
//   Path: an accepted character waits in the input register, is decoded
//   when the result register can take it, and its result is written into
//   that register, from which it is offered on the output channel.
//   Throughput: one character per cycle while out_ready stays high, set by
//   the single decode step between the input register and the result register.
//   Reset: clears both stage valid flags and returns the phase machine to
//   the state before an opening brace with zero position and no error.
//   Stall: while out_ready is low the result register holds, the input
//   register fills, and in_ready drops once both are occupied.
// ----------------------------------------------------------------------------
module flat_json_object_tokenizer #(
    parameter int MAX_STRING = 255,
    parameter int MAX_INPUT  = 2048
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fjot_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fjot_pkg::out_item_t out_data
);

    logic                item_valid;
    fjot_pkg::in_item_t  item;
    logic                load_ready;
    logic                step;
    fjot_pkg::out_item_t result;

    // Advance one character when the result register can take it
    assign step = item_valid && load_ready;

    fjot_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    fjot_core #(
        .MAX_STRING (MAX_STRING),
        .MAX_INPUT  (MAX_INPUT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .result (result)
    );

    fjot_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (item_valid),
        .load_ready (load_ready),
        .load_data  (result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
